// ----- design/multi_queue_round_robin_credit_fifo_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin credit queue block.
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_ROUND_ROBIN_CREDIT_FIFO_ASSERT_SVH
`define MULTI_QUEUE_ROUND_ROBIN_CREDIT_FIFO_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property outside reset.
`define MQRR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check a property on every edge, reset included.
`define MQRR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MQRR_ASSERT(lbl, clk, rst_n, prop, msg)
`define MQRR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- design/mqrr_pkg.sv -----
// ----------------------------------------------------------------------------
// mqrr_pkg
// Types and codes shared by the round-robin credit queue modules.
// ----------------------------------------------------------------------------
package mqrr_pkg;

    // Fixed field widths of one credit word.
    localparam int SUB_W   = 3;
    localparam int POS_W   = 24;
    localparam int DEPTH_W = 2;
    localparam int WORDS_W = 64;
    localparam int FANIN_W = 16;
    localparam int CHAN_W  = 8;
    localparam int STAT_W  = 3;

    // Stored credit record, 116 bits.
    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [DEPTH_W-1:0] depth;
        logic [WORDS_W-1:0] words;
        logic [FANIN_W-1:0] fanin;
        logic               repair;
        logic               mark;
        logic [CHAN_W-1:0]  chan;
    } t_credit;

    localparam int REC_W = $bits(t_credit);

    // Operation codes.
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_ENQ    = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADSUB = 3'd2;
    localparam logic [STAT_W-1:0] ST_POP    = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd4;

    // Commit request from the control to the pointer bank.
    typedef struct packed {
        logic             enq;
        logic             deq;
        logic [SUB_W-1:0] sub;
    } t_ptr_cmd;

    // Queue status from the pointer bank.
    typedef struct packed {
        logic             bad_sub;
        logic             full;
        logic             any_ready;
        logic [SUB_W-1:0] pop_sub;
    } t_ptr_stat;

endpackage

// ----- design/mqrr_store.sv -----
// ----------------------------------------------------------------------------
// mqrr_store
// Credit record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mqrr_store #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  mqrr_pkg::t_credit     i_wdata,
    input  logic                  i_re,
    input  logic [ADDR_W-1:0]     i_raddr,
    output mqrr_pkg::t_credit     o_rdata
);

    logic [mqrr_pkg::REC_W-1:0] mem [DEPTH];
    logic [mqrr_pkg::REC_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = mqrr_pkg::t_credit'(r_rdata);

endmodule

// ----- design/mqrr_ptrs.sv -----
// ----------------------------------------------------------------------------
// mqrr_ptrs
// Per-subchannel ring pointers, full and empty flags, round-robin selection.
// ----------------------------------------------------------------------------
`include "multi_queue_round_robin_credit_fifo_assert.svh"

module mqrr_ptrs #(
    parameter int QUEUE_DEPTH     = 4096,
    parameter int NUM_SUBCHANNELS = 2,
    parameter int PTR_W           = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mqrr_pkg::t_ptr_cmd     i_cmd,
    output mqrr_pkg::t_ptr_stat    o_stat,
    output logic [PTR_W-1:0]       o_wr_ptr,
    output logic [PTR_W-1:0]       o_rd_ptr
);

    localparam int SW = (NUM_SUBCHANNELS > 1) ? $clog2(NUM_SUBCHANNELS) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [PTR_W-1:0]           r_wr_ptr [NUM_SUBCHANNELS];
    logic [PTR_W-1:0]           r_rd_ptr [NUM_SUBCHANNELS];
    logic [SW-1:0]              r_rr;
    logic [NUM_SUBCHANNELS-1:0] full_vec;
    logic [NUM_SUBCHANNELS-1:0] empty_vec;
    logic [SW-1:0]              sub_idx;
    logic                       bad_sub;
    logic [SW-1:0]              sel;
    logic                       found;
    logic [SW-1:0]              n_rr;

    // Ring increment that wraps at the queue depth.
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    // Full and empty flags of every ring.
    for (genvar s = 0; s < NUM_SUBCHANNELS; s++) begin : g_flags
        assign full_vec[s]  = (ring_next(r_wr_ptr[s]) == r_rd_ptr[s]);
        assign empty_vec[s] = (r_wr_ptr[s] == r_rd_ptr[s]);
    end

    // Enqueue target check.
    assign bad_sub = ({1'b0, i_cmd.sub} >= 4'(NUM_SUBCHANNELS));
    assign sub_idx = i_cmd.sub[SW-1:0];

    // Round-robin search from the cursor for the first non-empty ring.
    always_comb begin
        logic [SW:0] idx;
        found = 1'b0;
        sel   = '0;
        idx   = '0;
        for (int k = 0; k < NUM_SUBCHANNELS; k++) begin
            idx = (SW+1)'(r_rr) + (SW+1)'(k);
            if (idx >= (SW+1)'(NUM_SUBCHANNELS)) begin
                idx = idx - (SW+1)'(NUM_SUBCHANNELS);
            end
            if (!found && !empty_vec[idx[SW-1:0]]) begin
                found = 1'b1;
                sel   = idx[SW-1:0];
            end
        end
    end

    // Cursor moves to the ring after the one popped.
    assign n_rr = (sel == SW'(NUM_SUBCHANNELS - 1)) ? '0 : sel + SW'(1);

    // Status towards the control.
    always_comb begin
        o_stat.bad_sub   = bad_sub;
        o_stat.full      = full_vec[sub_idx];
        o_stat.any_ready = found;
        o_stat.pop_sub   = mqrr_pkg::SUB_W'(sel);
    end

    assign o_wr_ptr = r_wr_ptr[sub_idx];
    assign o_rd_ptr = r_rd_ptr[sel];

    // Pointer and cursor registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SUBCHANNELS; s++) begin
                r_wr_ptr[s] <= '0;
                r_rd_ptr[s] <= '0;
            end
            r_rr <= '0;
        end else begin
            if (i_cmd.enq) begin
                r_wr_ptr[sub_idx] <= ring_next(r_wr_ptr[sub_idx]);
            end
            if (i_cmd.deq) begin
                r_rd_ptr[sel] <= ring_next(r_rd_ptr[sel]);
                r_rr          <= n_rr;
            end
        end
    end

    // A push only lands in a valid ring that has room.
    `MQRR_ASSERT(a_enq_room, i_clk, i_rst_n, i_cmd.enq |-> (!bad_sub && !full_vec[sub_idx]), "enqueue committed to a full or invalid ring")
    // A pop only comes from a ring that holds a record.
    `MQRR_ASSERT(a_deq_data, i_clk, i_rst_n, i_cmd.deq |-> found, "pop committed with every ring empty")
    // The cursor always names an existing subchannel.
    `MQRR_ASSERT(a_rr_range, i_clk, i_rst_n, (SW+1)'(r_rr) < (SW+1)'(NUM_SUBCHANNELS), "round-robin cursor out of range")

endmodule

// ----- design/multi_queue_round_robin_credit_fifo.sv -----
// ----------------------------------------------------------------------------
// multi_queue_round_robin_credit_fifo
// Credit rings per subchannel in one memory, drained in round-robin order.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                     Word
//  in       input      i_in_valid / o_in_ready       opcode and credit fields
//  out      output     o_out_valid / i_out_ready     status and popped credit
//
//  An enqueue, a dropped enqueue and a dequeue that finds every ring empty
//  are answered from the idle state; a pop passes the read state for its
//  memory read. A new word is taken while the previous result is being taken.
//  Reset clears the ring pointers and the cursor; the credit memory is not
//  cleared, as no slot is read before it has been written.
//  A stalled output holds its word and blocks new input until it is taken.
// ----------------------------------------------------------------------------
`include "multi_queue_round_robin_credit_fifo_assert.svh"

module multi_queue_round_robin_credit_fifo #(
    parameter int QUEUE_DEPTH     = 4096,
    parameter int NUM_SUBCHANNELS = 2,
    parameter int STACK_LEVELS    = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [2:0]  i_sub_index,
    input  logic [23:0] i_credit_pos,
    input  logic [1:0]  i_stack_depth_in,
    input  logic [63:0] i_stack_words_in,
    input  logic [15:0] i_fanin_bytes_in,
    input  logic        i_is_repair,
    input  logic        i_congestion_mark,
    input  logic [7:0]  i_chan_in,
    // Output channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [2:0]  o_sub_out,
    output logic [23:0] o_pos_out,
    output logic [1:0]  o_depth_out,
    output logic [63:0] o_stack_words_out,
    output logic [15:0] o_fanin_bytes_out,
    output logic        o_repair_out,
    output logic        o_mark_out,
    output logic [7:0]  o_chan_out
);

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int MEM_DEPTH = NUM_SUBCHANNELS * QUEUE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [63:0] WORD_MASK = (STACK_LEVELS >= 2) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                            : 64'h0000_0000_FFFF_FFFF;
    localparam logic [15:0] BYTE_MASK = (STACK_LEVELS >= 2) ? 16'hFFFF : 16'h00FF;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                r_state;
    logic                  r_out_valid;
    logic [2:0]            r_status;
    logic [2:0]            r_sub_out;
    mqrr_pkg::t_credit     r_out_rec;
    logic [2:0]            r_pop_sub;

    logic                  in_acc;
    logic                  out_acc;
    mqrr_pkg::t_ptr_cmd    ptr_cmd;
    mqrr_pkg::t_ptr_stat   ptr_stat;
    logic [PTR_W-1:0]      wr_ptr;
    logic [PTR_W-1:0]      rd_ptr;
    logic                  enq_ok;
    logic                  deq_ok;
    mqrr_pkg::t_credit     wr_rec;
    mqrr_pkg::t_credit     rd_rec;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;

    // Handshakes; a word is taken only in the idle state, when the output register is free or being emptied.
    assign out_acc    = r_out_valid && i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    // Commit decisions for the pointer bank.
    assign enq_ok = in_acc && (i_opcode == mqrr_pkg::OP_ENQ)
                    && !ptr_stat.bad_sub && !ptr_stat.full;
    assign deq_ok = in_acc && (i_opcode == mqrr_pkg::OP_DEQ) && ptr_stat.any_ready;

    always_comb begin
        ptr_cmd.enq = enq_ok;
        ptr_cmd.deq = deq_ok;
        ptr_cmd.sub = i_sub_index;
    end

    mqrr_ptrs #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .NUM_SUBCHANNELS (NUM_SUBCHANNELS),
        .PTR_W           (PTR_W)
    ) u_ptrs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (ptr_cmd),
        .o_stat   (ptr_stat),
        .o_wr_ptr (wr_ptr),
        .o_rd_ptr (rd_ptr)
    );

    // Record to store; a repair credit carries no stack.
    always_comb begin
        wr_rec.pos    = i_credit_pos;
        wr_rec.depth  = i_is_repair ? 2'd0 : i_stack_depth_in;
        wr_rec.words  = i_is_repair ? 64'd0 : (i_stack_words_in & WORD_MASK);
        wr_rec.fanin  = i_is_repair ? 16'd0 : (i_fanin_bytes_in & BYTE_MASK);
        wr_rec.repair = i_is_repair;
        wr_rec.mark   = i_congestion_mark;
        wr_rec.chan   = i_chan_in;
    end

    // Memory addresses: ring base plus slot.
    assign waddr = ADDR_W'(ADDR_W'(i_sub_index) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wr_ptr));
    assign raddr = ADDR_W'(ADDR_W'(ptr_stat.pop_sub) * ADDR_W'(QUEUE_DEPTH)
                           + ADDR_W'(rd_ptr));

    mqrr_store #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (enq_ok),
        .i_waddr (waddr),
        .i_wdata (wr_rec),
        .i_re    (deq_ok),
        .i_raddr (raddr),
        .o_rdata (rd_rec)
    );

    // Control sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        // The output register is free or being emptied here.
                        r_sub_out <= '0;
                        r_out_rec <= '0;
                        if (i_opcode == mqrr_pkg::OP_ENQ) begin
                            r_out_valid <= 1'b1;
                            if (ptr_stat.bad_sub) begin
                                r_status <= mqrr_pkg::ST_BADSUB;
                            end else if (ptr_stat.full) begin
                                r_status <= mqrr_pkg::ST_FULL;
                            end else begin
                                r_status <= mqrr_pkg::ST_ENQ;
                            end
                        end else if (ptr_stat.any_ready) begin
                            r_out_valid <= 1'b0;
                            r_pop_sub   <= ptr_stat.pop_sub;
                            r_state     <= S_READ;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_status    <= mqrr_pkg::ST_EMPTY;
                        end
                    end else if (out_acc) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_status    <= mqrr_pkg::ST_POP;
                    r_sub_out   <= r_pop_sub;
                    r_out_rec   <= rd_rec;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output ports.
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_sub_out         = r_sub_out;
    assign o_pos_out         = r_out_rec.pos;
    assign o_depth_out       = r_out_rec.depth;
    assign o_stack_words_out = r_out_rec.words;
    assign o_fanin_bytes_out = r_out_rec.fanin;
    assign o_repair_out      = r_out_rec.repair;
    assign o_mark_out        = r_out_rec.mark;
    assign o_chan_out        = r_out_rec.chan;

    // The read cycle never finds an unsent result in the output register.
    `MQRR_ASSERT(a_read_free, i_clk, i_rst_n, (r_state == S_READ) |-> !r_out_valid, "memory read would overwrite a pending result")
    // Every memory read turns into a pop result on the next edge.
    `MQRR_ASSERT(a_read_pop, i_clk, i_rst_n, (r_state == S_READ) |=> (o_out_valid && (o_status == mqrr_pkg::ST_POP)), "memory read not delivered as a pop")
    // A committed pop blocks input for its read cycle.
    `MQRR_ASSERT(a_pop_stall, i_clk, i_rst_n, deq_ok |=> ((r_state == S_READ) && !o_in_ready), "pop did not wait for the memory read")
    // Reset leaves no result pending.
    `MQRR_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> (!o_out_valid && (r_state == S_IDLE)), "result pending after reset")

endmodule

// ----- bench/tb_multi_queue_round_robin_credit_fifo.sv -----
// ----------------------------------------------------------------------------
// tb_multi_queue_round_robin_credit_fifo
// Self-checking bench for the round-robin credit queue block. A scoreboard
// keeps its own copy of the credit rings, their pointers and the round-robin
// cursor, predicts the status and popped credit of every accepted word, and
// compares each result in order. Stimulus runs a directed set, then random
// traffic with gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_queue_round_robin_credit_fifo;

    localparam int QDEPTH  = 4096;
    localparam int NSUB    = 2;
    localparam int NLEVELS = 2;

    // Masks for the stack levels that the block keeps.
    localparam logic [mqrr_pkg::WORDS_W-1:0] WORD_KEEP =
        (NLEVELS >= 2) ? {mqrr_pkg::WORDS_W{1'b1}} : 64'h0000_0000_FFFF_FFFF;
    localparam logic [mqrr_pkg::FANIN_W-1:0] FANIN_KEEP =
        (NLEVELS >= 2) ? 16'hFFFF : 16'h00FF;

    // Slowest correct run: about 1320 words, each with its longest gap, a pop
    // and its longest stall, stays under this limit.
    localparam int CYCLE_LIMIT = 500_000;

    // One predicted result word.
    typedef struct packed {
        logic [mqrr_pkg::STAT_W-1:0] status;
        logic [mqrr_pkg::SUB_W-1:0]  sub;
        mqrr_pkg::t_credit           rec;
    } t_credit_result;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the rings and the cursor, plus the results due.
    // ------------------------------------------------------------------------
    class t_credit_scoreboard;
        mqrr_pkg::t_credit ring_mem [NSUB][QDEPTH];
        int                wr_ptr [NSUB];
        int                rd_ptr [NSUB];
        int                cursor;
        t_credit_result    due_q [$];
        int                errors;
        int                n_enq, n_full, n_bad, n_pop, n_empty;

        function new();
            for (int s = 0; s < NSUB; s++) begin
                wr_ptr[s] = 0;
                rd_ptr[s] = 0;
            end
            cursor  = 0;
            errors  = 0;
            n_enq   = 0;
            n_full  = 0;
            n_bad   = 0;
            n_pop   = 0;
            n_empty = 0;
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction

        // Work out the result of one accepted word and update the mirror.
        function void note_word(logic op, logic [mqrr_pkg::SUB_W-1:0] sub,
                                mqrr_pkg::t_credit c);
            t_credit_result    r;
            mqrr_pkg::t_credit kept;
            int                nxt;
            int                s;
            int                si;
            bit                found;
            r     = '0;
            found = 0;
            si    = int'(sub);
            if (op == mqrr_pkg::OP_ENQ) begin
                if (si >= NSUB) begin
                    r.status = mqrr_pkg::ST_BADSUB;
                end else begin
                    nxt = (wr_ptr[si] + 1) % QDEPTH;
                    if (nxt == rd_ptr[si]) begin
                        r.status = mqrr_pkg::ST_FULL;
                    end else begin
                        // A repair credit carries no aggregation state.
                        kept.pos    = c.pos;
                        kept.depth  = c.repair ? '0 : c.depth;
                        kept.words  = c.repair ? '0 : (c.words & WORD_KEEP);
                        kept.fanin  = c.repair ? '0 : (c.fanin & FANIN_KEEP);
                        kept.repair = c.repair;
                        kept.mark   = c.mark;
                        kept.chan   = c.chan;
                        ring_mem[si][wr_ptr[si]] = kept;
                        wr_ptr[si] = nxt;
                        r.status = mqrr_pkg::ST_ENQ;
                    end
                end
            end else begin
                // Scan from the cursor for the first ring holding a credit.
                r.status = mqrr_pkg::ST_EMPTY;
                for (int i = 0; i < NSUB; i++) begin
                    s = (cursor + i) % NSUB;
                    if (!found && rd_ptr[s] != wr_ptr[s]) begin
                        found     = 1;
                        r.status  = mqrr_pkg::ST_POP;
                        r.sub     = s[mqrr_pkg::SUB_W-1:0];
                        r.rec     = ring_mem[s][rd_ptr[s]];
                        rd_ptr[s] = (rd_ptr[s] + 1) % QDEPTH;
                        cursor    = (s + 1) % NSUB;
                    end
                end
            end
            due_q.push_back(r);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= 40)
                $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                         $time, what, got, want);
        endtask

        // Compare one accepted result word with the oldest prediction.
        task check_result(logic [mqrr_pkg::STAT_W-1:0] status,
                          logic [mqrr_pkg::SUB_W-1:0] sub, mqrr_pkg::t_credit rec);
            t_credit_result e;
            if (due_q.size() == 0) begin
                report_mismatch("result with no word outstanding", 64'(status), '0);
            end else begin
                e = due_q.pop_front();
                case (e.status)
                    mqrr_pkg::ST_ENQ:    n_enq++;
                    mqrr_pkg::ST_FULL:   n_full++;
                    mqrr_pkg::ST_BADSUB: n_bad++;
                    mqrr_pkg::ST_POP:    n_pop++;
                    default:             n_empty++;
                endcase
                if (status !== e.status)
                    report_mismatch("status", 64'(status), 64'(e.status));
                if (sub !== e.sub)
                    report_mismatch("subchannel", 64'(sub), 64'(e.sub));
                if (rec.pos !== e.rec.pos)
                    report_mismatch("offset", 64'(rec.pos), 64'(e.rec.pos));
                if (rec.depth !== e.rec.depth)
                    report_mismatch("depth", 64'(rec.depth), 64'(e.rec.depth));
                if (rec.words !== e.rec.words)
                    report_mismatch("stack words", rec.words, e.rec.words);
                if (rec.fanin !== e.rec.fanin)
                    report_mismatch("fan-in bytes", 64'(rec.fanin), 64'(e.rec.fanin));
                if (rec.repair !== e.rec.repair)
                    report_mismatch("repair mark", 64'(rec.repair), 64'(e.rec.repair));
                if (rec.mark !== e.rec.mark)
                    report_mismatch("congestion mark", 64'(rec.mark), 64'(e.rec.mark));
                if (rec.chan !== e.rec.chan)
                    report_mismatch("channel id", 64'(rec.chan), 64'(e.rec.chan));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block.
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_opcode;
    logic [2:0]  i_sub_index;
    logic [23:0] i_credit_pos;
    logic [1:0]  i_stack_depth_in;
    logic [63:0] i_stack_words_in;
    logic [15:0] i_fanin_bytes_in;
    logic        i_is_repair;
    logic        i_congestion_mark;
    logic [7:0]  i_chan_in;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic [2:0]  o_sub_out;
    logic [23:0] o_pos_out;
    logic [1:0]  o_depth_out;
    logic [63:0] o_stack_words_out;
    logic [15:0] o_fanin_bytes_out;
    logic        o_repair_out;
    logic        o_mark_out;
    logic [7:0]  o_chan_out;

    t_credit_scoreboard sb;
    bit                 idle_on;
    int                 stall_left;
    int                 cycle_count;

    multi_queue_round_robin_credit_fifo #(
        .QUEUE_DEPTH     (QDEPTH),
        .NUM_SUBCHANNELS (NSUB),
        .STACK_LEVELS    (NLEVELS)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_sub_index       (i_sub_index),
        .i_credit_pos      (i_credit_pos),
        .i_stack_depth_in  (i_stack_depth_in),
        .i_stack_words_in  (i_stack_words_in),
        .i_fanin_bytes_in  (i_fanin_bytes_in),
        .i_is_repair       (i_is_repair),
        .i_congestion_mark (i_congestion_mark),
        .i_chan_in         (i_chan_in),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_sub_out         (o_sub_out),
        .o_pos_out         (o_pos_out),
        .o_depth_out       (o_depth_out),
        .o_stack_words_out (o_stack_words_out),
        .o_fanin_bytes_out (o_fanin_bytes_out),
        .o_repair_out      (o_repair_out),
        .o_mark_out        (o_mark_out),
        .o_chan_out        (o_chan_out)
    );

    // Clock with a 12 ns period.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Run limit.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Helpers for stimulus.
    // ------------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function mqrr_pkg::t_credit mk_credit(logic [23:0] pos, logic [1:0] depth,
                                          logic [63:0] words, logic [15:0] fanin,
                                          logic rep, logic mark, logic [7:0] chan);
        mqrr_pkg::t_credit c;
        c.pos    = pos;
        c.depth  = depth;
        c.words  = words;
        c.fanin  = fanin;
        c.repair = rep;
        c.mark   = mark;
        c.chan   = chan;
        return c;
    endfunction

    function mqrr_pkg::t_credit rand_credit();
        return mk_credit(24'($urandom_range(0, 24'hFFFFFF)), 2'($urandom_range(0, 3)),
                         {$urandom, $urandom}, 16'($urandom_range(0, 16'hFFFF)),
                         ($urandom_range(0, 99) < 20), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
    endfunction

    // Present one word and hold it until the block takes it.
    task send_word(logic op, logic [2:0] sub, mqrr_pkg::t_credit c);
        i_in_valid        <= 1'b1;
        i_opcode          <= op;
        i_sub_index       <= sub;
        i_credit_pos      <= c.pos;
        i_stack_depth_in  <= c.depth;
        i_stack_words_in  <= c.words;
        i_fanin_bytes_in  <= c.fanin;
        i_is_repair       <= c.repair;
        i_congestion_mark <= c.mark;
        i_chan_in         <= c.chan;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(op, sub, c);
    endtask

    // Optional idle cycles after a word.
    task sender_gap();
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the input back until every result is in, then let the block settle.
    task wait_drained();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Random traffic with a given share of enqueues.
    task random_traffic(int n_words, int enq_pct);
        logic [2:0] sub;
        for (int k = 0; k < n_words; k++) begin
            // Most enqueues target a real subchannel.
            sub = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, NSUB - 1))
                                               : 3'($urandom_range(0, 7));
            send_word(($urandom_range(0, 99) < enq_pct) ? mqrr_pkg::OP_ENQ
                                                        : mqrr_pkg::OP_DEQ,
                      sub, rand_credit());
            sender_gap();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: take words with random stalls and check them.
    // ------------------------------------------------------------------------
    initial begin
        i_out_ready <= 1'b0;
        stall_left   = 0;
    end

    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && i_out_ready === 1'b1)
            sb.check_result(o_status, o_sub_out,
                            mqrr_pkg::t_credit'({o_pos_out, o_depth_out, o_stack_words_out,
                                                 o_fanin_bytes_out, o_repair_out,
                                                 o_mark_out, o_chan_out}));
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 99) < 30)
                stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        sb                 = new();
        idle_on            = 1'b1;
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_opcode          <= mqrr_pkg::OP_ENQ;
        i_sub_index       <= '0;
        i_credit_pos      <= '0;
        i_stack_depth_in  <= '0;
        i_stack_words_in  <= '0;
        i_fanin_bytes_in  <= '0;
        i_is_repair       <= 1'b0;
        i_congestion_mark <= 1'b0;
        i_chan_in         <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a dequeue with nothing queued, then extremes of every field.
        send_word(mqrr_pkg::OP_DEQ, 3'd0, rand_credit());
        send_word(mqrr_pkg::OP_ENQ, 3'd0, mk_credit(24'hFFFFFF, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF,
                                                    16'hFFFF, 1'b0, 1'b1, 8'hFF));
        send_word(mqrr_pkg::OP_ENQ, 3'd1, mk_credit(24'h0, 2'd0, 64'h0, 16'h0,
                                                    1'b0, 1'b0, 8'h0));
        // Repair credit: its stack, fan-in and depth are dropped.
        send_word(mqrr_pkg::OP_ENQ, 3'd0, mk_credit(24'h123456, 2'd2, 64'hDEAD_BEEF_CAFE_F00D,
                                                    16'hA55A, 1'b1, 1'b0, 8'h5A));
        // Out-of-range subchannels.
        send_word(mqrr_pkg::OP_ENQ, 3'd2, mk_credit(24'hABCDEF, 2'd1, 64'h1, 16'h1,
                                                    1'b0, 1'b1, 8'h1));
        send_word(mqrr_pkg::OP_ENQ, 3'd7, mk_credit(24'h000001, 2'd2, 64'h2, 16'h2,
                                                    1'b1, 1'b1, 8'h2));
        send_word(mqrr_pkg::OP_ENQ, 3'd1, mk_credit(24'hAAAAAA, 2'd1, 64'hAAAA_AAAA_5555_5555,
                                                    16'h55AA, 1'b0, 1'b1, 8'hA5));
        // Dequeues carry stray field values; they alternate between the rings.
        repeat (4) send_word(mqrr_pkg::OP_DEQ, 3'd7, rand_credit());
        send_word(mqrr_pkg::OP_DEQ, 3'd1, mk_credit(24'hFFFFFF, 2'd3, '1, '1,
                                                    1'b1, 1'b1, 8'hFF));
        // An empty scan must leave the cursor where the last pop put it.
        send_word(mqrr_pkg::OP_ENQ, 3'd1, rand_credit());
        send_word(mqrr_pkg::OP_DEQ, 3'd0, rand_credit());
        send_word(mqrr_pkg::OP_DEQ, 3'd0, rand_credit());
        send_word(mqrr_pkg::OP_ENQ, 3'd1, rand_credit());
        send_word(mqrr_pkg::OP_ENQ, 3'd0, rand_credit());
        send_word(mqrr_pkg::OP_DEQ, 3'd0, rand_credit());
        send_word(mqrr_pkg::OP_DEQ, 3'd0, rand_credit());
        send_word(mqrr_pkg::OP_DEQ, 3'd0, rand_credit());
        wait_drained();

        // Random traffic with varying balance; the last stretch runs without gaps.
        random_traffic(325, 65);
        wait_drained();
        random_traffic(325, 50);
        random_traffic(325, 35);
        wait_drained();
        idle_on = 1'b0;
        random_traffic(325, 55);
        idle_on = 1'b1;
        wait_drained();

        $display("Checked %0d results: %0d queued, %0d refused at a full ring, %0d refused",
                 sb.n_enq + sb.n_full + sb.n_bad + sb.n_pop + sb.n_empty,
                 sb.n_enq, sb.n_full, sb.n_bad);
        $display("for a bad subchannel, %0d popped in round-robin order, %0d empty scans.",
                 sb.n_pop, sb.n_empty);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.outstanding());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
